[src/hashed_address_tag_cache_assert.svh]
// ---------------------------------------------------------------------------
// hashed address tag cache assertion macros
// shared property forms for the tag cache checks, clocked on clk, off in reset
// ---------------------------------------------------------------------------
`ifndef HASHED_ADDRESS_TAG_CACHE_ASSERT_SVH
`define HASHED_ADDRESS_TAG_CACHE_ASSERT_SVH

// same-cycle implication
`define HATC_ASSERT_SAME(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication
`define HATC_ASSERT_NEXT(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

[src/hatc_pkg.sv]
// ---------------------------------------------------------------------------
// hatc_pkg
// field widths and hash constants shared by the tag cache modules
// ---------------------------------------------------------------------------
`default_nettype none

package hatc_pkg;

	localparam int unsigned ADDR_W  = 64;
	localparam int unsigned SLOT_W  = 12;
	localparam int unsigned PROBE_W = 4;
	localparam int unsigned COUNT_W = 13;
	localparam int unsigned MUL_W   = 32;

	localparam logic [ADDR_W-1:0]  HASH_MULT  = 64'h9E37_79B9_7F4A_7C15;
	localparam int unsigned        HASH_SHIFT = 45;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

endpackage

`default_nettype wire

[src/hashed_address_tag_cache.sv]
// ---------------------------------------------------------------------------
// hashed_address_tag_cache
// open addressing tag table with fibonacci hash and bounded linear probing
// ---------------------------------------------------------------------------
// Usage: a transaction is accepted at a rising edge where start is high and
// busy is low; lookup_address is sampled there. The address is hashed with
// three passes through one shared 32x32 multiplier, then slots are
// probed one at a time through the single read port of the tag ram, each
// probe a read and then a compare. A miss then writes the key back.
// The result appears on the result ports for exactly one cycle, marked by
// done, which is registered from the compare on a hit and from the
// write-back otherwise; probes_used is 1 to PROBE_LIMIT. busy is low during
// the done cycle, so a new transaction may start there; none is accepted
// while busy is high, so one transaction is in flight at a time.
// The receiver cannot stall; results are not held past their done cycle.
// After reset the tag ram is cleared one slot a cycle, all TABLE_SIZE slots
// (4096 by default), with busy high; the claim count resets to zero.
// ---------------------------------------------------------------------------
`default_nettype none

`include "hashed_address_tag_cache_assert.svh"

module hashed_address_tag_cache #(
	parameter int unsigned TABLE_SIZE  = 4096,
	parameter int unsigned PROBE_LIMIT = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [hatc_pkg::ADDR_W-1:0]     lookup_address,
	output logic                                 done,
	output logic                                 hit,
	output logic      [hatc_pkg::SLOT_W-1:0]     slot_index,
	output logic                                 claimed_empty,
	output logic                                 evicted_other,
	output logic      [hatc_pkg::PROBE_W-1:0]    probes_used,
	output logic      [hatc_pkg::COUNT_W-1:0]    entries_claimed
);

	localparam int unsigned IDX_W    = $clog2(TABLE_SIZE);
	localparam int unsigned PW       = $clog2(PROBE_LIMIT + 1);
	localparam int unsigned MW       = hatc_pkg::MUL_W;
	localparam int unsigned HI_SHIFT = hatc_pkg::HASH_SHIFT - MW;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_H0,
		S_H1,
		S_H2,
		S_H3,
		S_RD,
		S_CMP,
		S_WR
	} state_t;

	state_t                        state_q;
	logic [hatc_pkg::ADDR_W-1:0]   key_q;
	logic [MW-1:0]                 hi_q;
	logic [IDX_W-1:0]              idx_q;
	logic [IDX_W-1:0]              clr_idx_q;
	logic [PW-1:0]                 probe_q;
	logic                          claim_q;
	logic                          evict_q;
	logic                          hit_q;
	logic                          done_q;
	logic [hatc_pkg::COUNT_W-1:0]  count_q;

	logic [MW-1:0]                 mul_a;
	logic [MW-1:0]                 mul_b;
	logic [2*MW-1:0]               mul_p_s1;
	logic [MW-1:0]                 hi_sum;

	logic                          ram_we;
	logic [IDX_W-1:0]              ram_waddr;
	logic [hatc_pkg::ADDR_W-1:0]   ram_wdata;
	logic                          ram_re;
	logic [hatc_pkg::ADDR_W-1:0]   ram_rdata;

	logic                          accept;
	logic                          last_probe;

	// operand select for the three partial products of the low 64 bits
	always_comb begin
		unique case (state_q)
			S_H1: begin
				mul_a = key_q[MW-1:0];
				mul_b = hatc_pkg::HASH_MULT[2*MW-1:MW];
			end
			S_H2: begin
				mul_a = key_q[2*MW-1:MW];
				mul_b = hatc_pkg::HASH_MULT[MW-1:0];
			end
			default: begin
				mul_a = key_q[MW-1:0];
				mul_b = hatc_pkg::HASH_MULT[MW-1:0];
			end
		endcase
	end

	hatc_mul u_mul (
		.clk        (clk),
		.a          (mul_a),
		.b          (mul_b),
		.product_s1 (mul_p_s1)
	);

	assign hi_sum = hi_q + mul_p_s1[MW-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = key_q;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
			ram_wdata = '0;
		end else if (state_q == S_WR) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re = (state_q == S_RD);

	hatc_ram #(
		.WIDTH (hatc_pkg::ADDR_W),
		.DEPTH (TABLE_SIZE)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign last_probe = (probe_q == PW'(PROBE_LIMIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			key_q     <= '0;
			hi_q      <= '0;
			idx_q     <= '0;
			clr_idx_q <= '0;
			probe_q   <= '0;
			claim_q   <= 1'b0;
			evict_q   <= 1'b0;
			hit_q     <= 1'b0;
			done_q    <= 1'b0;
			count_q   <= '0;
		end else begin
			// result ends on a hit compare or on the write-back
			done_q <= (state_q == S_WR) || ((state_q == S_CMP) && (ram_rdata == key_q));
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						key_q   <= lookup_address;
						state_q <= S_H0;
					end
				end
				S_H0: begin
					state_q <= S_H1;
				end
				S_H1: begin
					hi_q    <= mul_p_s1[2*MW-1:MW];
					state_q <= S_H2;
				end
				S_H2: begin
					hi_q    <= hi_sum;
					state_q <= S_H3;
				end
				S_H3: begin
					idx_q   <= hi_sum[HI_SHIFT +: IDX_W];
					probe_q <= PW'(1);
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					priority if (ram_rdata == key_q) begin
						hit_q   <= 1'b1;
						claim_q <= 1'b0;
						evict_q <= 1'b0;
						state_q <= S_IDLE;
					end else if (ram_rdata == '0) begin
						hit_q   <= 1'b0;
						claim_q <= 1'b1;
						evict_q <= 1'b0;
						state_q <= S_WR;
					end else if (last_probe) begin
						hit_q   <= 1'b0;
						claim_q <= 1'b0;
						evict_q <= 1'b1;
						state_q <= S_WR;
					end else begin
						idx_q   <= idx_q + 1'b1;
						probe_q <= probe_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_WR: begin
					if (claim_q && (count_q != hatc_pkg::COUNT_MAX)) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done            = done_q;
	assign hit             = hit_q;
	assign slot_index      = hatc_pkg::SLOT_W'(idx_q);
	assign claimed_empty   = claim_q;
	assign evicted_other   = evict_q;
	assign probes_used     = hatc_pkg::PROBE_W'(probe_q);
	assign entries_claimed = count_q;

	// checks
	`HATC_ASSERT_SAME(a_flags_onehot, done_q, $onehot({hit_q, claim_q, evict_q}),
		"result flags not one-hot")
	`HATC_ASSERT_SAME(a_probe_range, done_q,
		(probe_q != '0) && (probe_q <= PW'(PROBE_LIMIT)), "probe count out of range")
	`HATC_ASSERT_NEXT(a_busy_after_accept, accept, busy && !done_q,
		"accepted transaction not held busy")
	`HATC_ASSERT_NEXT(a_done_single, done_q, !done_q, "done held for more than one cycle")

endmodule

`default_nettype wire

[src/hatc_ram.sv]
// ---------------------------------------------------------------------------
// hatc_ram
// generic single write port, single read port ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module hatc_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[src/hatc_mul.sv]
// ---------------------------------------------------------------------------
// hatc_mul
// shared 32 by 32 multiplier with a registered product
// ---------------------------------------------------------------------------
`default_nettype none

module hatc_mul (
	input  wire logic                        clk,
	input  wire logic [hatc_pkg::MUL_W-1:0]  a,
	input  wire logic [hatc_pkg::MUL_W-1:0]  b,
	output logic      [2*hatc_pkg::MUL_W-1:0] product_s1
);

	always_ff @(posedge clk) begin
		product_s1 <= a * b;
	end

endmodule

`default_nettype wire

[sim/tb_hashed_address_tag_cache.sv]
// ---------------------------------------------------------------------------
// tb_hashed_address_tag_cache
// self-checking bench for the hashed address tag cache: a queue-fed driver
// issues lookup transactions and predicts each result with its own mirror of
// the tag table and claim count; a monitor checks every done strobe, field by
// field, against the oldest prediction. Directed lookups cover address zero,
// the extremes, a probe chain that wraps the table end, eviction and zero
// overwriting a full chain; random lookups mix repeats, clustered keys built
// to land on chosen home slots, zero and sparse patterns.
// ---------------------------------------------------------------------------
module tb_hashed_address_tag_cache;

	localparam int unsigned TABLE_SIZE  = 4096;
	localparam int unsigned PROBE_LIMIT = 8;

	localparam int unsigned ADDR_W     = hatc_pkg::ADDR_W;
	localparam int unsigned SLOT_W     = hatc_pkg::SLOT_W;
	localparam int unsigned PROBE_W    = hatc_pkg::PROBE_W;
	localparam int unsigned COUNT_W    = hatc_pkg::COUNT_W;
	localparam int unsigned HASH_SHIFT = hatc_pkg::HASH_SHIFT;

	localparam logic [ADDR_W-1:0]  HASH_MULT = hatc_pkg::HASH_MULT;
	localparam logic [COUNT_W-1:0] COUNT_MAX = hatc_pkg::COUNT_MAX;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		bit                calm;
		bit                drain;
	} lookup_item_t;

	typedef struct {
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic               claimed;
		logic               evicted;
		logic [PROBE_W-1:0] probes;
		logic [COUNT_W-1:0] count;
	} lookup_result_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                start;
	logic                busy;
	logic [ADDR_W-1:0]   lookup_address;
	logic                done;
	logic                hit;
	logic [SLOT_W-1:0]   slot_index;
	logic                claimed_empty;
	logic                evicted_other;
	logic [PROBE_W-1:0]  probes_used;
	logic [COUNT_W-1:0]  entries_claimed;

	logic [ADDR_W-1:0]   tag_mirror [TABLE_SIZE];
	logic [COUNT_W-1:0]  claims_mirror;
	logic [ADDR_W-1:0]   mult_inverse;

	lookup_item_t        lookup_queue[$];
	lookup_result_t      pending_results[$];
	lookup_item_t        next_item;
	lookup_result_t      predicted;
	lookup_result_t      oldest;
	int                  idle_left;
	int                  accepted_cnt;
	int                  results_seen;
	int                  mismatches;

	hashed_address_tag_cache #(
		.TABLE_SIZE(TABLE_SIZE),
		.PROBE_LIMIT(PROBE_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.lookup_address(lookup_address),
		.done(done),
		.hit(hit),
		.slot_index(slot_index),
		.claimed_empty(claimed_empty),
		.evicted_other(evicted_other),
		.probes_used(probes_used),
		.entries_claimed(entries_claimed)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic probe_table(input logic [ADDR_W-1:0] key, output lookup_result_t r);
		logic [ADDR_W-1:0] product;
		logic [ADDR_W-1:0] shifted;
		logic [SLOT_W-1:0] idx;
		logic [SLOT_W-1:0] last;
		int                n;
		bit                found;
		bit                empty;
		product = key * HASH_MULT;
		shifted = product >> HASH_SHIFT;
		idx     = shifted[SLOT_W-1:0];
		last    = idx;
		n       = 0;
		found   = 1'b0;
		empty   = 1'b0;
		while (n < PROBE_LIMIT && !found && !empty) begin
			last = idx;
			n++;
			if (tag_mirror[idx] == key)
				found = 1'b1;
			else if (tag_mirror[idx] == '0)
				empty = 1'b1;
			else
				idx = idx + 1'b1;
		end
		if (!found) begin
			tag_mirror[last] = key;
			if (empty && claims_mirror != COUNT_MAX)
				claims_mirror = claims_mirror + 1'b1;
		end
		r.hit     = found;
		r.slot    = last;
		r.claimed = empty;
		r.evicted = !found && !empty;
		r.probes  = n[PROBE_W-1:0];
		r.count   = claims_mirror;
	endtask

	// key whose hash lands on the given home slot, other product bits random
	function automatic logic [ADDR_W-1:0] key_for_slot(input logic [SLOT_W-1:0] slot);
		logic [ADDR_W-1:0] product;
		product = {$urandom, $urandom};
		product[HASH_SHIFT +: SLOT_W] = slot;
		return product * mult_inverse;
	endfunction

	task automatic add_item(input logic [ADDR_W-1:0] addr, input bit calm, input bit drain);
		lookup_item_t it;
		it.addr  = addr;
		it.calm  = calm;
		it.drain = drain;
		lookup_queue.push_back(it);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t mismatch on %s: expected %0h actual %0h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start          <= 1'b0;
			lookup_address <= '0;
			idle_left      = 0;
			accepted_cnt   = 0;
		end else begin
			if (start && !busy) begin
				probe_table(lookup_address, predicted);
				pending_results.push_back(predicted);
				accepted_cnt++;
			end
			if (start && busy) begin
				// hold the transaction until accepted
			end else if (idle_left > 0) begin
				idle_left--;
				start          <= 1'b0;
				lookup_address <= {$urandom, $urandom};
			end else if (lookup_queue.size() > 0 &&
					!(lookup_queue[0].drain && results_seen != accepted_cnt)) begin
				next_item = lookup_queue.pop_front();
				start          <= 1'b1;
				lookup_address <= next_item.addr;
				if (!next_item.calm && $urandom_range(0, 4) == 0)
					idle_left = $urandom_range(1, 17);
			end else begin
				start          <= 1'b0;
				lookup_address <= {$urandom, $urandom};
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_seen <= 0;
		end else if (done) begin
			results_seen <= results_seen + 1;
			if (pending_results.size() == 0) begin
				$display("%0t unexpected transaction: expected none actual slot %0h", $time,
					slot_index);
				mismatches++;
			end else begin
				oldest = pending_results.pop_front();
				check_field("hit", oldest.hit, hit);
				check_field("slot_index", oldest.slot, slot_index);
				check_field("claimed_empty", oldest.claimed, claimed_empty);
				check_field("evicted_other", oldest.evicted, evicted_other);
				check_field("probes_used", oldest.probes, probes_used);
				check_field("entries_claimed", oldest.count, entries_claimed);
			end
		end
	end

	initial begin
		logic [ADDR_W-1:0] chain [0:8];
		logic [ADDR_W-1:0] near6;
		logic [ADDR_W-1:0] near7;
		logic [ADDR_W-1:0] k;
		logic [ADDR_W-1:0] key_pool[$];
		logic [SLOT_W-1:0] hot [0:5];
		int                r;
		mismatches    = 0;
		claims_mirror = '0;
		for (int i = 0; i < TABLE_SIZE; i++)
			tag_mirror[i] = '0;
		mult_inverse = HASH_MULT;
		repeat (6)
			mult_inverse = mult_inverse * (64'd2 - HASH_MULT * mult_inverse);

		// directed
		add_item('0, 1'b0, 1'b0);
		add_item('1, 1'b0, 1'b0);
		add_item('1, 1'b0, 1'b0);
		add_item(64'd1, 1'b0, 1'b0);
		add_item(64'h8000_0000_0000_0000, 1'b0, 1'b0);
		// chain over the table end, ninth key runs out of probes
		for (int i = 0; i < 9; i++) begin
			chain[i] = key_for_slot(12'hFFE);
			add_item(chain[i], 1'b0, 1'b0);
		end
		near6 = key_for_slot(12'd6);
		near7 = key_for_slot(12'd7);
		add_item(near6, 1'b0, 1'b0);
		add_item(near7, 1'b0, 1'b0);
		// zero through a full run of slots
		add_item('0, 1'b0, 1'b0);
		add_item(near7, 1'b0, 1'b0);
		add_item(chain[8], 1'b0, 1'b0);
		add_item(chain[0], 1'b0, 1'b0);
		add_item(chain[7], 1'b0, 1'b0);

		// random
		for (int i = 0; i < 950; i++) begin
			if (i % 150 == 0) begin
				for (int j = 0; j < 6; j++)
					hot[j] = $urandom_range(0, TABLE_SIZE - 1);
				hot[0] = 12'hFFD;
			end
			r = $urandom_range(0, 99);
			if (r < 30 && key_pool.size() > 0)
				k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			else if (r < 65)
				k = key_for_slot(hot[$urandom_range(0, 5)] + SLOT_W'($urandom_range(0, 3)));
			else if (r < 72)
				k = '0;
			else if (r < 80) begin
				k = 64'd1 << $urandom_range(0, 63);
				if ($urandom_range(0, 1) == 1)
					k = ~k;
			end else
				k = {$urandom, $urandom};
			key_pool.push_back(k);
			if (key_pool.size() > 200)
				void'(key_pool.pop_front());
			add_item(k, i >= 830, i == 0 || i == 475);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (lookup_queue.size() != 0 || start)
			@(posedge clk);
		while (results_seen < accepted_cnt)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t %0d transaction(s) expected but never completed", $time,
				pending_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("%0t timeout", $time);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/hatc_pkg.sv
src/hatc_ram.sv
src/hatc_mul.sv
src/hashed_address_tag_cache.sv
sim/tb_hashed_address_tag_cache.sv
